### rtl/rsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

    localparam int CORDIC_N = 24;
    localparam int GUARD = 20;
    localparam logic [19:0] INVK_Q20 = 20'd636751;
    localparam int QBITS = 34;
    localparam int SXW = QBITS + 3;
    localparam int LQW = SXW + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOV     = 3'd0,
        REG_MARGIN  = 3'd1,
        REG_PPD     = 3'd2,
        REG_TILE    = 3'd3,
        REG_WWIDTH  = 3'd4,
        REG_WHEIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic        visible;
        logic [16:0] distance;
        logic [15:0] aoff;
        logic [12:0] lift;
        logic        fpos;
    } hdiv_side_t;

    typedef struct packed {
        logic lneg;
        logic lnz;
    } sdiv_side_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/raycast_sprite_projection.sv
`timescale 1ns / 1ps
`default_nettype none

// Sprite projection pipeline: one sprite may be started in every cycle and
// busy is never raised. The result of a sprite appears with a one-cycle done
// pulse; the pipeline holds two input stages, two 24-step CORDIC units working
// side by side, two stages of fix-up and products, two 34-step radix-2
// dividers side by side, and three stages of row and column arithmetic. The
// receiver cannot hold results off, so each result must be taken in the cycle
// that done is high. Configuration registers are written with cfg_we and take
// effect for sprites started after the write; write them only when no sprite
// is in flight.
module raycast_sprite_projection
    import rsp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_BITS-1:0]  sprite_x,
    input  logic [COORD_BITS-1:0]  sprite_y,
    input  logic [COORD_BITS-1:0]  player_x,
    input  logic [COORD_BITS-1:0]  player_y,
    input  logic [ANGLE_BITS-1:0]  view_angle,
    input  logic signed [12:0]     lift_offset,
    output logic                   done,
    output logic                   visible,
    output logic [16:0]            distance,
    output logic [15:0]            angle_off,
    output logic [15:0]            sprite_height,
    output logic [11:0]            top_row,
    output logic [11:0]            bottom_row,
    output logic signed [15:0]     left_col,
    output logic signed [15:0]     right_col
);

    localparam int CB  = COORD_BITS;
    localparam int AB  = ANGLE_BITS;
    localparam int W   = CB + 23;
    localparam int LW  = W - 16;
    localparam int SNB = LW + 24;
    localparam int NB  = (SNB > QBITS + 1) ? SNB : QBITS + 1;
    localparam int VSB = AB + 13;
    localparam int VW  = (AB + 2 > 17) ? AB + 2 : 17;
    localparam int DVW = (W - 19 > 17) ? W - 19 : 17;
    localparam int AOW = (AB + 1 > 16) ? AB + 1 : 16;
    localparam int LATENCY = 2 + (CORDIC_N + 1) + 2 + (QBITS + 1) + 3;

    function automatic logic signed [15:0] sat16(input logic signed [LQW-1:0] v);
        logic signed [15:0] r;
        if (v > LQW'(32767))
            r = 16'sh7FFF;
        else if (v < -LQW'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // Configuration registers.
    logic [14:0] fov_reg;
    logic [13:0] margin_reg;
    logic [15:0] ppd_reg;
    logic [9:0]  tile_reg;
    logic [11:0] wwidth_reg;
    logic [11:0] wheight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fov_reg     <= 15'd10923;
            margin_reg  <= 14'd2086;
            ppd_reg     <= 16'd693;
            tile_reg    <= 10'd64;
            wwidth_reg  <= 12'd800;
            wheight_reg <= 12'd600;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FOV:     fov_reg     <= cfg_data[14:0];
                REG_MARGIN:  margin_reg  <= cfg_data[13:0];
                REG_PPD:     ppd_reg     <= cfg_data[15:0];
                REG_TILE:    tile_reg    <= cfg_data[9:0];
                REG_WWIDTH:  wwidth_reg  <= cfg_data[11:0];
                REG_WHEIGHT: wheight_reg <= cfg_data[11:0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: vector from viewer to sprite.
    logic                a_valid_reg;
    logic signed [CB:0]  a_dx_reg;
    logic signed [CB:0]  a_dy_reg;
    logic [AB-1:0]       a_view_reg;
    logic [12:0]         a_lift_reg;
    logic signed [CB:0]  dx;
    logic signed [CB:0]  dy;

    assign dx = $signed({1'b0, sprite_x}) - $signed({1'b0, player_x});
    assign dy = $signed({1'b0, sprite_y}) - $signed({1'b0, player_y});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= start & ~busy;
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg   <= dx;
        a_dy_reg   <= dy;
        a_view_reg <= view_angle;
        a_lift_reg <= lift_offset;
    end

    // Stage B: scale by the inverse CORDIC gain.
    logic                b_valid_reg;
    logic signed [W-1:0] b_x_reg;
    logic signed [W-1:0] b_y_reg;
    logic [AB-1:0]       b_view_reg;
    logic [12:0]         b_lift_reg;
    logic                b_nz_reg;
    logic signed [CB+21:0] px;
    logic signed [CB+21:0] py;

    assign px = a_dx_reg * $signed({1'b0, INVK_Q20});
    assign py = a_dy_reg * $signed({1'b0, INVK_Q20});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        b_x_reg    <= {{(W-CB-22){px[CB+21]}}, px};
        b_y_reg    <= {{(W-CB-22){py[CB+21]}}, py};
        b_view_reg <= a_view_reg;
        b_lift_reg <= a_lift_reg;
        b_nz_reg   <= (a_dx_reg != '0) || (a_dy_reg != '0);
    end

    // CORDIC units.
    logic                v_valid;
    logic [W-1:0]        v_mag;
    logic [31:0]         v_ang;
    logic [VSB-1:0]      v_side;
    logic                r_valid;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_y;
    logic                r_nz;

    rsp_cordic_vec #(
        .W  (W),
        .SB (VSB)
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .x_in      (b_x_reg),
        .y_in      (b_y_reg),
        .side_in   ({b_view_reg, b_lift_reg}),
        .out_valid (v_valid),
        .mag       (v_mag),
        .angle     (v_ang),
        .side_out  (v_side)
    );

    rsp_cordic_rot #(
        .W  (W),
        .AB (AB),
        .SB (1)
    ) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .x_in      (b_x_reg),
        .y_in      (b_y_reg),
        .view      (b_view_reg),
        .side_in   (b_nz_reg),
        .out_valid (r_valid),
        .x_out     (r_x),
        .y_out     (r_y),
        .side_out  (r_nz)
    );

    // Stage P1: bearing, angle offset, distance, forward and lateral.
    logic [AB-1:0]  c_view;
    logic [12:0]    c_lift;
    logic [31:0]    zr;
    logic [AB-1:0]  bear;
    logic [AB-1:0]  diff;
    logic [AB:0]    aoff;
    logic [AOW-1:0] aoff_x;
    logic [VW-1:0]  vis_lhs;
    logic [VW-1:0]  vis_rhs;
    logic [W:0]     dsum;
    logic [DVW-1:0] dvx;
    logic [16:0]    dist_sat;
    logic signed [LW-1:0] f8;
    logic signed [LW-1:0] l8;
    logic [LW-1:0]  absl;

    assign c_view = v_side[VSB-1:13];
    assign c_lift = v_side[12:0];

    always_comb
    begin
        zr      = v_ang + (32'd1 << (31 - AB));
        bear    = r_nz ? zr[31:32-AB] : '0;
        diff    = c_view - bear;
        aoff    = diff[AB-1] ? ({1'b1, {AB{1'b0}}} - {1'b0, diff}) : {1'b0, diff};
        aoff_x  = AOW'(aoff);
        vis_lhs = VW'({aoff, 1'b0});
        vis_rhs = VW'(fov_reg) + VW'({margin_reg, 1'b0});
        dsum    = {1'b0, v_mag} + (W+1)'(1 << (GUARD - 1));
        dvx     = DVW'(dsum[W:GUARD]);
        dist_sat = (dvx > DVW'(131071)) ? 17'd131071 : dvx[16:0];
        f8      = r_x[W-1:16];
        l8      = r_y[W-1:16];
        absl    = l8[LW-1] ? LW'(-l8) : LW'(l8);
    end

    logic                 p1_valid_reg;
    logic                 p1_vis_reg;
    logic [16:0]          p1_dist_reg;
    logic [15:0]          p1_aoff_reg;
    logic [12:0]          p1_lift_reg;
    logic                 p1_fpos_reg;
    logic                 p1_lneg_reg;
    logic                 p1_lnz_reg;
    logic [LW-1:0]        p1_f8_reg;
    logic [LW-1:0]        p1_absl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else
            p1_valid_reg <= v_valid & r_valid;
    end

    always_ff @(posedge clk)
    begin
        p1_vis_reg  <= vis_lhs < vis_rhs;
        p1_dist_reg <= dist_sat;
        p1_aoff_reg <= aoff_x[15:0];
        p1_lift_reg <= c_lift;
        p1_fpos_reg <= !f8[LW-1] && (f8 != '0);
        p1_lneg_reg <= l8[LW-1];
        p1_lnz_reg  <= l8 != '0;
        p1_f8_reg   <= f8;
        p1_absl_reg <= absl;
    end

    // Stage P2: dividends and divisor.
    logic              p2_valid_reg;
    logic [NB-1:0]     p2_hnum_reg;
    logic [NB-1:0]     p2_snum_reg;
    logic [LW-1:0]     p2_den_reg;
    hdiv_side_t        p2_hside_reg;
    sdiv_side_t        p2_sside_reg;
    logic [25:0]       tp;
    logic [LW+15:0]    lp;

    assign tp = tile_reg * ppd_reg;
    assign lp = p1_absl_reg * ppd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        p2_hnum_reg  <= NB'({tp, 8'b0});
        p2_snum_reg  <= NB'({lp, 8'b0});
        p2_den_reg   <= p1_fpos_reg ? p1_f8_reg : LW'(1);
        p2_hside_reg <= '{visible: p1_vis_reg, distance: p1_dist_reg, aoff: p1_aoff_reg,
                          lift: p1_lift_reg, fpos: p1_fpos_reg};
        p2_sside_reg <= '{lneg: p1_lneg_reg, lnz: p1_lnz_reg};
    end

    // Dividers.
    logic                        hd_valid;
    logic [QBITS-1:0]            hq;
    logic                        hq_rnz;
    logic [$bits(hdiv_side_t)-1:0] hd_side;
    logic                        sd_valid;
    logic [QBITS-1:0]            sq;
    logic                        sq_rnz;
    logic [$bits(sdiv_side_t)-1:0] sd_side;
    hdiv_side_t                  hs;
    sdiv_side_t                  ss;

    rsp_div #(
        .NB (NB),
        .DB (LW),
        .QB (QBITS),
        .SB ($bits(hdiv_side_t))
    ) u_hdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .num       (p2_hnum_reg),
        .den       (p2_den_reg),
        .side_in   (p2_hside_reg),
        .out_valid (hd_valid),
        .quo       (hq),
        .rem_nz    (hq_rnz),
        .side_out  (hd_side)
    );

    rsp_div #(
        .NB (NB),
        .DB (LW),
        .QB (QBITS),
        .SB ($bits(sdiv_side_t))
    ) u_sdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .num       (p2_snum_reg),
        .den       (p2_den_reg),
        .side_in   (p2_sside_reg),
        .out_valid (sd_valid),
        .quo       (sq),
        .rem_nz    (sq_rnz),
        .side_out  (sd_side)
    );

    assign hs = hdiv_side_t'(hd_side);
    assign ss = sdiv_side_t'(sd_side);

    // Stage Q1: height with cap, signed screen offset.
    logic [24:0]            h_c;
    logic signed [SXW-1:0]  sx_c;
    logic [SXW-1:0]         smag;

    always_comb
    begin
        smag = SXW'(sq) + SXW'(sq_rnz & ss.lneg);
        if (!hs.fpos)
            h_c = 25'h100_0000;
        else if (hq > QBITS'(25'h100_0000) || (hq_rnz && 1'b0))
            h_c = 25'h100_0000;
        else
            h_c = hq[24:0];
        if (!hs.fpos)
        begin
            if (!ss.lnz)
                sx_c = '0;
            else if (ss.lneg)
                sx_c = -$signed(SXW'(1) << QBITS);
            else
                sx_c = $signed(SXW'(1) << QBITS);
        end
        else if (ss.lneg)
            sx_c = -$signed(smag);
        else
            sx_c = $signed(SXW'(sq));
    end

    logic                   q1_valid_reg;
    logic [24:0]            q1_h_reg;
    logic signed [SXW-1:0]  q1_sx_reg;
    hdiv_side_t             q1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q1_valid_reg <= 1'b0;
        else
            q1_valid_reg <= hd_valid & sd_valid;
    end

    always_ff @(posedge clk)
    begin
        q1_h_reg    <= h_c;
        q1_sx_reg   <= sx_c;
        q1_side_reg <= hs;
    end

    // Stage Q2: doubled row edges and Q8 column edges.
    logic signed [27:0]     hh2;
    logic signed [27:0]     lift2;
    logic signed [27:0]     hx;
    logic signed [LQW-1:0]  whq;
    logic signed [LQW-1:0]  sxq;
    logic signed [LQW-1:0]  h128;

    assign hh2   = $signed({16'b0, wheight_reg[11:1], 1'b0});
    assign lift2 = {{14{q1_side_reg.lift[12]}}, q1_side_reg.lift, 1'b0};
    assign hx    = $signed({3'b0, q1_h_reg});
    assign whq   = $signed(LQW'({wwidth_reg[11:1], 8'b0}));
    assign sxq   = {{(LQW-SXW){q1_sx_reg[SXW-1]}}, q1_sx_reg};
    assign h128  = $signed(LQW'({q1_h_reg, 7'b0}));

    logic                   q2_valid_reg;
    logic signed [27:0]     q2_t2_reg;
    logic signed [27:0]     q2_b2_reg;
    logic signed [LQW-1:0]  q2_lq_reg;
    logic signed [LQW-1:0]  q2_rq_reg;
    logic [15:0]            q2_height_reg;
    hdiv_side_t             q2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q2_valid_reg <= 1'b0;
        else
            q2_valid_reg <= q1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        q2_t2_reg     <= hh2 - hx + lift2;
        q2_b2_reg     <= hh2 + hx + lift2;
        q2_lq_reg     <= whq + sxq - h128;
        q2_rq_reg     <= whq + sxq + h128;
        q2_height_reg <= (q1_h_reg > 25'd65535) ? 16'hFFFF : q1_h_reg[15:0];
        q2_side_reg   <= q1_side_reg;
    end

    // Stage Q3: clamps and output registers.
    logic signed [27:0]    tsh;
    logic signed [27:0]    bsh;
    logic [11:0]           top_c;
    logic [11:0]           bot_c;
    logic signed [LQW-1:0] rq_up;

    always_comb
    begin
        tsh   = q2_t2_reg >>> 1;
        bsh   = (q2_b2_reg + 28'sd1) >>> 1;
        rq_up = q2_rq_reg + LQW'(255);
        if (q2_t2_reg < 0)
            top_c = '0;
        else if (tsh > 28'sd4095)
            top_c = 12'hFFF;
        else
            top_c = tsh[11:0];
        if (q2_b2_reg <= 0)
            bot_c = '0;
        else if (bsh > $signed({16'b0, wheight_reg}))
            bot_c = wheight_reg;
        else
            bot_c = bsh[11:0];
    end

    logic               done_reg;
    logic               visible_reg;
    logic [16:0]        distance_reg;
    logic [15:0]        angle_off_reg;
    logic [15:0]        height_reg;
    logic [11:0]        top_reg;
    logic [11:0]        bottom_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= q2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        visible_reg   <= q2_side_reg.visible;
        distance_reg  <= q2_side_reg.distance;
        angle_off_reg <= q2_side_reg.aoff;
        height_reg    <= q2_height_reg;
        top_reg       <= top_c;
        bottom_reg    <= bot_c;
        left_reg      <= sat16(q2_lq_reg >>> 8);
        right_reg     <= sat16(rq_up >>> 8);
    end

    assign done          = done_reg;
    assign visible       = visible_reg;
    assign distance      = distance_reg;
    assign angle_off     = angle_off_reg;
    assign sprite_height = height_reg;
    assign top_row       = top_reg;
    assign bottom_row    = bottom_reg;
    assign left_col      = left_reg;
    assign right_col     = right_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(start, LATENCY))
        else $error("Result transfer without a matching start.");

    a_bottom_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (bottom_reg <= wheight_reg))
        else $error("Bottom row beyond window height.");

    a_cols_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (left_reg <= right_reg))
        else $error("Left column right of right column.");

endmodule

`default_nettype wire

### rtl/rsp_cordic_vec.sv
`timescale 1ns / 1ps
`default_nettype none

module rsp_cordic_vec
    import rsp_pkg::*;
#(
    parameter int W  = 39,
    parameter int SB = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  logic [SB-1:0]       side_in,
    output logic                out_valid,
    output logic [W-1:0]        mag,
    output logic [31:0]         angle,
    output logic [SB-1:0]       side_out
);

    logic signed [W-1:0] x_reg [0:CORDIC_N];
    logic signed [W-1:0] y_reg [0:CORDIC_N];
    logic [31:0]         z_reg [0:CORDIC_N];
    logic [SB-1:0]       side_reg [0:CORDIC_N];
    logic [CORDIC_N:0]   valid_reg;

    logic signed [W-1:0] x_next [0:CORDIC_N-1];
    logic signed [W-1:0] y_next [0:CORDIC_N-1];
    logic [31:0]         z_next [0:CORDIC_N-1];

    logic signed [W-1:0] x_pre;
    logic signed [W-1:0] y_pre;
    logic [31:0]         z_pre;

    // A vector in the left half plane is turned by a half turn first.
    always_comb
    begin
        if (x_in[W-1])
        begin
            x_pre = -x_in;
            y_pre = -y_in;
            z_pre = 32'h8000_0000;
        end
        else
        begin
            x_pre = x_in;
            y_pre = y_in;
            z_pre = 32'h0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (!y_reg[i][W-1])
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + atan_entry(i);
            end
            else
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - atan_entry(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CORDIC_N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_pre;
        y_reg[0]    <= y_pre;
        z_reg[0]    <= z_pre;
        side_reg[0] <= side_in;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            x_reg[i+1]    <= x_next[i];
            y_reg[i+1]    <= y_next[i];
            z_reg[i+1]    <= z_next[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[CORDIC_N];
    assign mag       = x_reg[CORDIC_N];
    assign angle     = z_reg[CORDIC_N];
    assign side_out  = side_reg[CORDIC_N];

endmodule

`default_nettype wire

### rtl/rsp_cordic_rot.sv
`timescale 1ns / 1ps
`default_nettype none

module rsp_cordic_rot
    import rsp_pkg::*;
#(
    parameter int W  = 39,
    parameter int AB = 16,
    parameter int SB = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] x_in,
    input  logic signed [W-1:0] y_in,
    input  logic [AB-1:0]       view,
    input  logic [SB-1:0]       side_in,
    output logic                out_valid,
    output logic signed [W-1:0] x_out,
    output logic signed [W-1:0] y_out,
    output logic [SB-1:0]       side_out
);

    logic signed [W-1:0] x_reg [0:CORDIC_N];
    logic signed [W-1:0] y_reg [0:CORDIC_N];
    logic signed [33:0]  z_reg [0:CORDIC_N];
    logic [SB-1:0]       side_reg [0:CORDIC_N];
    logic [CORDIC_N:0]   valid_reg;

    logic signed [W-1:0] x_next [0:CORDIC_N-1];
    logic signed [W-1:0] y_next [0:CORDIC_N-1];
    logic signed [33:0]  z_next [0:CORDIC_N-1];

    logic signed [W-1:0] x_pre;
    logic signed [W-1:0] y_pre;
    logic signed [33:0]  z_pre;
    logic [31:0]         th;
    logic [31:0]         th_off;
    logic [31:0]         th_adj;

    // Rotate by minus the heading; a target angle outside a quarter turn
    // is brought in by a half turn and a negation of the vector.
    always_comb
    begin
        th     = 32'h0 - {view, {(32-AB){1'b0}}};
        th_off = th - 32'h4000_0000;
        if (!th_off[31])
        begin
            x_pre  = -x_in;
            y_pre  = -y_in;
            th_adj = th ^ 32'h8000_0000;
        end
        else
        begin
            x_pre  = x_in;
            y_pre  = y_in;
            th_adj = th;
        end
        z_pre = {{2{th_adj[31]}}, th_adj};
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_N; i++)
        begin
            if (!z_reg[i][33])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed({2'b00, atan_entry(i)});
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed({2'b00, atan_entry(i)});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[CORDIC_N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x_pre;
        y_reg[0]    <= y_pre;
        z_reg[0]    <= z_pre;
        side_reg[0] <= side_in;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            x_reg[i+1]    <= x_next[i];
            y_reg[i+1]    <= y_next[i];
            z_reg[i+1]    <= z_next[i];
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = valid_reg[CORDIC_N];
    assign x_out     = x_reg[CORDIC_N];
    assign y_out     = y_reg[CORDIC_N];
    assign side_out  = side_reg[CORDIC_N];

endmodule

`default_nettype wire

### rtl/rsp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rsp_div
#(
    parameter int NB = 47,
    parameter int DB = 23,
    parameter int QB = 34,
    parameter int SB = 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NB-1:0] num,
    input  logic [DB-1:0] den,
    input  logic [SB-1:0] side_in,
    output logic          out_valid,
    output logic [QB-1:0] quo,
    output logic          rem_nz,
    output logic [SB-1:0] side_out
);

    localparam int HB = NB - QB;
    localparam int CW = (HB > DB) ? HB : DB;

    logic [DB-1:0] r_reg [0:QB];
    logic [NB-1:0] n_reg [0:QB];
    logic [QB-1:0] q_reg [0:QB];
    logic [DB-1:0] d_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic [SB-1:0] side_reg [0:QB];
    logic [QB:0]   valid_reg;

    logic [DB-1:0] r_next [0:QB-1];
    logic [QB-1:0] q_next [0:QB-1];

    logic [CW-1:0] hi;
    logic          ovf_pre;
    logic [DB:0]   rr [0:QB-1];

    // A quotient that does not fit in QB bits is flagged and saturates.
    always_comb
    begin
        hi      = CW'(num[NB-1:QB]);
        ovf_pre = hi >= CW'(den);
    end

    always_comb
    begin
        for (int s = 0; s < QB; s++)
        begin
            rr[s]     = {r_reg[s], n_reg[s][QB-1-s]};
            q_next[s] = q_reg[s];
            if (rr[s] >= {1'b0, d_reg[s]})
            begin
                r_next[s]           = DB'(rr[s] - {1'b0, d_reg[s]});
                q_next[s][QB-1-s]   = 1'b1;
            end
            else
            begin
                r_next[s] = rr[s][DB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QB-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= ovf_pre ? '0 : hi[DB-1:0];
        n_reg[0]    <= num;
        q_reg[0]    <= '0;
        d_reg[0]    <= den;
        ovf_reg[0]  <= ovf_pre;
        side_reg[0] <= side_in;
        for (int s = 0; s < QB; s++)
        begin
            r_reg[s+1]    <= r_next[s];
            n_reg[s+1]    <= n_reg[s];
            q_reg[s+1]    <= q_next[s];
            d_reg[s+1]    <= d_reg[s];
            ovf_reg[s+1]  <= ovf_reg[s];
            side_reg[s+1] <= side_reg[s];
        end
    end

    assign out_valid = valid_reg[QB];
    assign quo       = ovf_reg[QB] ? '1 : q_reg[QB];
    assign rem_nz    = ovf_reg[QB] | (r_reg[QB] != '0);
    assign side_out  = side_reg[QB];

endmodule

`default_nettype wire
